>>> src/ppi_pkg.sv
`timescale 1ns / 1ps

package ppi_pkg;

  // parallel tolerance after reset, Q1.14
  localparam logic [14:0] TOL_RESET = 15'd1638;

  // one in Q4.28, widened for the dot product compares
  localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

  // stages in front of the lanes: products, sums, squares, cross terms,
  // partial products, partial sums, numerator, magnitude
  localparam int unsigned FRONT_STAGES = 8;

  // quotient bits of the point division and of the direction division
  localparam int unsigned PQ_BITS = 32;
  localparam int unsigned DQ_BITS = 29;

  // digit steps of the square root
  localparam int unsigned SQRT_STEPS = 15;

  // lane stage map
  localparam int unsigned PT_RND_STAGE  = PQ_BITS;
  localparam int unsigned PT_SAT_STAGE  = PQ_BITS + 1;
  localparam int unsigned SQRT_FIRST    = DQ_BITS;
  localparam int unsigned DIR_RND_STAGE = SQRT_FIRST + SQRT_STEPS;
  localparam int unsigned LANE_STAGES   = DIR_RND_STAGE + 1;

  localparam int unsigned PIPE_STAGES = FRONT_STAGES + LANE_STAGES;

  // state carried by one lane stage
  typedef struct packed {
    logic [63:0]  s;      // squared cross product length, divisor
    logic [63:0]  pr;     // point division remainder
    logic [31:0]  pq;     // point quotient
    logic [31:0]  pbits;  // dividend bits still to shift in
    logic         psat;   // quotient at least 2^32
    logic         pneg;
    logic [32:0]  pm;     // rounded point magnitude
    logic [31:0]  pout;   // signed, saturated point component
    logic [63:0]  dr;     // direction division remainder
    logic [28:0]  dq;     // direction quotient
    logic         dneg;
    logic [30:0]  sx;     // square root remainder
    logic [30:0]  sres;   // square root result
  } lane_st_t;

endpackage

>>> src/plane_plane_intersection_unit.sv
`timescale 1ns / 1ps
// throughput: one word per cycle; the whole pipeline holds while a result waits
// an accepted input word passes 8 front stages, the 45-stage lanes (bit-per-stage divisions,
// digit-per-stage root) and the output register on the way to its result word
// reset clears the word valid bits and the output valid and loads the parallel tolerance with 1638

module plane_plane_intersection_unit import ppi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] first_normal_x_i,
  input  logic signed [15:0] first_normal_y_i,
  input  logic signed [15:0] first_normal_z_i,
  input  logic signed [31:0] first_offset_i,
  input  logic signed [15:0] second_normal_x_i,
  input  logic signed [15:0] second_normal_y_i,
  input  logic signed [15:0] second_normal_z_i,
  input  logic signed [31:0] second_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               line_valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic signed [15:0] direction_x_o,
  output logic signed [15:0] direction_y_o,
  output logic signed [15:0] direction_z_o
);

  logic        en;
  logic [14:0] tol_q;
  logic        vld_q [PIPE_STAGES];
  logic        out_valid_q;

  logic signed [15:0] n1 [3];
  logic signed [15:0] n2 [3];

  // stage 1
  logic signed [31:0] pdot_q [3];
  logic signed [31:0] pu_q [6];
  logic signed [15:0] n1_q1 [3];
  logic signed [15:0] n2_q1 [3];
  logic signed [31:0] d1_q1, d2_q1;
  // stage 2
  logic signed [33:0] dot_q;
  logic signed [32:0] u_q [3];
  logic signed [15:0] n1_q2 [3];
  logic signed [15:0] n2_q2 [3];
  logic signed [31:0] d1_q2, d2_q2;
  // stage 3
  logic signed [34:0] dot_x, upper, lower;
  logic               par_d;
  logic [31:0]        um [3];
  logic               par_q3;
  logic [63:0]        usq_q3 [3];
  logic               uneg_q3 [3];
  logic signed [48:0] ca_q [6];
  logic signed [48:0] cb_q [6];
  logic signed [31:0] d1_q3, d2_q3;
  // stage 4
  logic               par_q4;
  logic [63:0]        s_q4;
  logic signed [48:0] c1_q4 [3];
  logic signed [48:0] c2_q4 [3];
  logic [63:0]        usq_q4 [3];
  logic               uneg_q4 [3];
  logic signed [31:0] d1_q4, d2_q4;
  // stage 5
  logic signed [56:0] pl1_q [3];
  logic signed [56:0] ph1_q [3];
  logic signed [56:0] pl2_q [3];
  logic signed [56:0] ph2_q [3];
  logic               lv_q5;
  logic [63:0]        s_q5;
  logic [63:0]        usq_q5 [3];
  logic               uneg_q5 [3];
  // stage 6
  logic signed [80:0] p1_q [3];
  logic signed [80:0] p2_q [3];
  logic               lv_q6;
  logic [63:0]        s_q6;
  logic [63:0]        usq_q6 [3];
  logic               uneg_q6 [3];
  // stage 7
  logic signed [81:0] num_q [3];
  logic               lv_q7;
  logic [63:0]        s_q7;
  logic [63:0]        usq_q7 [3];
  logic               uneg_q7 [3];
  // stage 8
  logic [81:0]        nmag [3];
  logic [94:0]        mag_q [3];
  logic               pneg_q [3];
  logic               lv_q8;
  logic [63:0]        s_q8;
  logic [63:0]        usq_q8 [3];
  logic               uneg_q8 [3];
  // lanes and output
  logic               lv_pipe_q [LANE_STAGES];
  logic signed [31:0] lane_point [3];
  logic signed [15:0] lane_dir [3];
  logic               line_valid_q;
  logic signed [31:0] point_q [3];
  logic signed [15:0] dir_q [3];

  // one stall for the whole pipeline, released when the output frees up
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PIPE_STAGES; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      if (en) begin
        vld_q[0] <= in_valid_i;
        for (int i = 1; i < PIPE_STAGES; i++) begin
          vld_q[i] <= vld_q[i-1];
        end
        out_valid_q <= vld_q[PIPE_STAGES-1];
      end
    end
  end

  // input normals as vectors
  always_comb begin
    n1[0] = first_normal_x_i;
    n1[1] = first_normal_y_i;
    n1[2] = first_normal_z_i;
    n2[0] = second_normal_x_i;
    n2[1] = second_normal_y_i;
    n2[2] = second_normal_z_i;
  end

  // parallel test against one plus or minus the tolerance, magnitudes of u and of the numerator
  always_comb begin
    dot_x = 35'(dot_q);
    upper = ONE_Q28 + $signed({6'b0, tol_q, 14'b0});
    lower = ONE_Q28 - $signed({6'b0, tol_q, 14'b0});
    par_d = (dot_x < upper && dot_x > lower) || (dot_x > -upper && dot_x < -lower);
    for (int i = 0; i < 3; i++) begin
      um[i] = 32'(u_q[i] < 0 ? -u_q[i] : u_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      nmag[i] = num_q[i] < 0 ? 82'(-num_q[i]) : 82'(num_q[i]);
    end
  end

  // front pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      // products for dot and cross
      for (int i = 0; i < 3; i++) begin
        pdot_q[i] <= n1[i] * n2[i];
      end
      pu_q[0] <= n1[1] * n2[2];
      pu_q[1] <= n1[2] * n2[1];
      pu_q[2] <= n1[2] * n2[0];
      pu_q[3] <= n1[0] * n2[2];
      pu_q[4] <= n1[0] * n2[1];
      pu_q[5] <= n1[1] * n2[0];
      n1_q1   <= n1;
      n2_q1   <= n2;
      d1_q1   <= first_offset_i;
      d2_q1   <= second_offset_i;

      // dot product and cross product u
      dot_q <= 34'(pdot_q[0]) + 34'(pdot_q[1]) + 34'(pdot_q[2]);
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= 33'(pu_q[2*i]) - 33'(pu_q[2*i+1]);
      end
      n1_q2 <= n1_q1;
      n2_q2 <= n2_q1;
      d1_q2 <= d1_q1;
      d2_q2 <= d2_q1;

      // squares of u and products for n1 x u, n2 x u
      par_q3 <= par_d;
      for (int i = 0; i < 3; i++) begin
        usq_q3[i]  <= 64'(um[i]) * 64'(um[i]);
        uneg_q3[i] <= u_q[i] < 0;
      end
      ca_q[0] <= n1_q2[1] * u_q[2];
      ca_q[1] <= n1_q2[2] * u_q[1];
      ca_q[2] <= n1_q2[2] * u_q[0];
      ca_q[3] <= n1_q2[0] * u_q[2];
      ca_q[4] <= n1_q2[0] * u_q[1];
      ca_q[5] <= n1_q2[1] * u_q[0];
      cb_q[0] <= n2_q2[1] * u_q[2];
      cb_q[1] <= n2_q2[2] * u_q[1];
      cb_q[2] <= n2_q2[2] * u_q[0];
      cb_q[3] <= n2_q2[0] * u_q[2];
      cb_q[4] <= n2_q2[0] * u_q[1];
      cb_q[5] <= n2_q2[1] * u_q[0];
      d1_q3   <= d1_q2;
      d2_q3   <= d2_q2;

      // |u|^2 and the two cross products
      par_q4 <= par_q3;
      s_q4   <= usq_q3[0] + usq_q3[1] + usq_q3[2];
      for (int i = 0; i < 3; i++) begin
        c1_q4[i] <= ca_q[2*i] - ca_q[2*i+1];
        c2_q4[i] <= cb_q[2*i] - cb_q[2*i+1];
      end
      usq_q4  <= usq_q3;
      uneg_q4 <= uneg_q3;
      d1_q4   <= d1_q3;
      d2_q4   <= d2_q3;

      // split products with the offsets, degenerate check
      for (int i = 0; i < 3; i++) begin
        pl1_q[i] <= $signed({1'b0, c1_q4[i][23:0]}) * d2_q4;
        ph1_q[i] <= $signed(c1_q4[i][48:24]) * d2_q4;
        pl2_q[i] <= $signed({1'b0, c2_q4[i][23:0]}) * d1_q4;
        ph2_q[i] <= $signed(c2_q4[i][48:24]) * d1_q4;
      end
      lv_q5   <= !par_q4 && (s_q4 != 64'd0);
      s_q5    <= s_q4;
      usq_q5  <= usq_q4;
      uneg_q5 <= uneg_q4;

      // join partial products
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= $signed({ph1_q[i], 24'b0}) + 81'(pl1_q[i]);
        p2_q[i] <= $signed({ph2_q[i], 24'b0}) + 81'(pl2_q[i]);
      end
      lv_q6   <= lv_q5;
      s_q6    <= s_q5;
      usq_q6  <= usq_q5;
      uneg_q6 <= uneg_q5;

      // numerator d2 (n1 x u) - d1 (n2 x u)
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= 82'(p1_q[i]) - 82'(p2_q[i]);
      end
      lv_q7   <= lv_q6;
      s_q7    <= s_q6;
      usq_q7  <= usq_q6;
      uneg_q7 <= uneg_q6;

      // magnitude scaled to Q16.16 before the division
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= {nmag[i][80:0], 14'b0};
        pneg_q[i] <= num_q[i] < 0;
      end
      lv_q8   <= lv_q7;
      s_q8    <= s_q7;
      usq_q8  <= usq_q7;
      uneg_q8 <= uneg_q7;

      // line valid follows the lanes
      lv_pipe_q[0] <= lv_q8;
      for (int i = 1; i < LANE_STAGES; i++) begin
        lv_pipe_q[i] <= lv_pipe_q[i-1];
      end

      // output word, zero when no line
      line_valid_q <= lv_pipe_q[LANE_STAGES-1];
      for (int i = 0; i < 3; i++) begin
        point_q[i] <= lv_pipe_q[LANE_STAGES-1] ? lane_point[i] : 32'sd0;
        dir_q[i]   <= lv_pipe_q[LANE_STAGES-1] ? lane_dir[i] : 16'sd0;
      end
    end
  end

  // one division and root lane per axis
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ppi_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .s_i     (s_q8),
      .mag_i   (mag_q[i]),
      .pneg_i  (pneg_q[i]),
      .sq_i    (usq_q8[i]),
      .dneg_i  (uneg_q8[i]),
      .point_o (lane_point[i]),
      .dir_o   (lane_dir[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign line_valid_o  = line_valid_q;
  assign point_x_o     = point_q[0];
  assign point_y_o     = point_q[1];
  assign point_z_o     = point_q[2];
  assign direction_x_o = dir_q[0];
  assign direction_y_o = dir_q[1];
  assign direction_z_o = dir_q[2];

endmodule

>>> src/ppi_lane.sv
`timescale 1ns / 1ps

module ppi_lane import ppi_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [63:0]        s_i,
  input  logic [94:0]        mag_i,
  input  logic               pneg_i,
  input  logic [63:0]        sq_i,
  input  logic               dneg_i,
  output logic signed [31:0] point_o,
  output logic signed [15:0] dir_o
);

  lane_st_t init;
  lane_st_t st_q [LANE_STAGES];
  lane_st_t st_d [LANE_STAGES];
  logic [15:0] dmag;

  // work of one stage, chosen by its place in the lane
  function automatic lane_st_t lane_step(lane_st_t cur, int unsigned k);
    lane_st_t    nxt;
    logic [64:0] s_x;
    logic [64:0] pt;
    logic [64:0] dt;
    logic [30:0] x_in;
    logic [30:0] r_in;
    logic [30:0] bit_v;
    logic [30:0] sum;
    logic        ovf;
    int unsigned j;
    nxt   = cur;
    s_x   = {1'b0, cur.s};
    pt    = '0;
    dt    = '0;
    x_in  = '0;
    r_in  = '0;
    bit_v = '0;
    sum   = '0;
    ovf   = 1'b0;
    j     = 0;

    // point: one restoring division step
    if (k < PQ_BITS) begin
      if (k == 0) begin
        nxt.psat = (cur.pr >= cur.s);
      end
      pt = {cur.pr, cur.pbits[PQ_BITS-1]};
      if (pt >= s_x) begin
        nxt.pr = 64'(pt - s_x);
        nxt.pq = {cur.pq[PQ_BITS-2:0], 1'b1};
      end else begin
        nxt.pr = pt[63:0];
        nxt.pq = {cur.pq[PQ_BITS-2:0], 1'b0};
      end
      nxt.pbits = cur.pbits << 1;
    end

    // point: round half away from zero
    if (k == PT_RND_STAGE) begin
      nxt.pm = {1'b0, cur.pq} + 33'({cur.pr, 1'b0} >= s_x);
    end

    // point: saturate and apply sign
    if (k == PT_SAT_STAGE) begin
      ovf = cur.psat || (cur.pneg ? (cur.pm > 33'h080000000) : (cur.pm > 33'h07fffffff));
      if (ovf) begin
        nxt.pout = cur.pneg ? 32'h80000000 : 32'h7fffffff;
      end else begin
        nxt.pout = cur.pneg ? (~cur.pm[31:0] + 32'd1) : cur.pm[31:0];
      end
    end

    // direction: u_i^2 * 2^28 / s, first step without shift
    if (k < DQ_BITS) begin
      dt = (k == 0) ? {1'b0, cur.dr} : {cur.dr, 1'b0};
      if (dt >= s_x) begin
        nxt.dr = 64'(dt - s_x);
        nxt.dq = {cur.dq[DQ_BITS-2:0], 1'b1};
      end else begin
        nxt.dr = dt[63:0];
        nxt.dq = {cur.dq[DQ_BITS-2:0], 1'b0};
      end
    end

    // direction: one digit of the square root
    if (k >= SQRT_FIRST && k < SQRT_FIRST + SQRT_STEPS) begin
      j     = k - SQRT_FIRST;
      bit_v = 31'(1) << (2 * (SQRT_STEPS - 1 - j));
      x_in  = (k == SQRT_FIRST) ? 31'(cur.dq) : cur.sx;
      r_in  = (k == SQRT_FIRST) ? '0 : cur.sres;
      sum   = r_in + bit_v;
      if (x_in >= sum) begin
        nxt.sx   = x_in - sum;
        nxt.sres = (r_in >> 1) + bit_v;
      end else begin
        nxt.sx   = x_in;
        nxt.sres = r_in >> 1;
      end
    end

    // direction: round the root to nearest
    if (k == DIR_RND_STAGE) begin
      nxt.sres = cur.sres + 31'(cur.sx > cur.sres);
    end
    return nxt;
  endfunction

  // lane entry
  always_comb begin
    init       = '0;
    init.s     = s_i;
    init.pr    = {1'b0, mag_i[94:32]};
    init.pbits = mag_i[31:0];
    init.pneg  = pneg_i;
    init.dr    = sq_i;
    init.dneg  = dneg_i;
  end

  // next value of every stage
  always_comb begin
    for (int unsigned k = 0; k < LANE_STAGES; k++) begin
      if (k == 0) begin
        st_d[k] = lane_step(init, k);
      end else begin
        st_d[k] = lane_step(st_q[k-1], k);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned k = 0; k < LANE_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // lane results
  assign point_o = $signed(st_q[LANE_STAGES-1].pout);
  assign dmag    = st_q[LANE_STAGES-1].sres[15:0];
  assign dir_o   = $signed(st_q[LANE_STAGES-1].dneg ? (~dmag + 16'd1) : dmag);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppi_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] ad;
    logic signed [15:0] bx, by, bz;
    logic signed [31:0] bd;
  } plane_pair_t;

  typedef struct {
    logic               found;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
  } line_t;

  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES    = PIPE_STAGES + 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [14:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] first_normal_x_i = '0;
  logic signed [15:0] first_normal_y_i = '0;
  logic signed [15:0] first_normal_z_i = '0;
  logic signed [31:0] first_offset_i = '0;
  logic signed [15:0] second_normal_x_i = '0;
  logic signed [15:0] second_normal_y_i = '0;
  logic signed [15:0] second_normal_z_i = '0;
  logic signed [31:0] second_offset_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               line_valid_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  logic signed [15:0] direction_x_o, direction_y_o, direction_z_o;

  plane_pair_t pending_pairs[$];
  line_t       expected_lines[$];
  plane_pair_t offered_pair;
  logic [14:0] tolerance_now = TOL_RESET;
  bit          quiet = 1'b0;
  int          in_count = 0;
  int          line_count = 0;
  int          found_count = 0;
  int          error_count = 0;
  int          stall_cycles = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  plane_plane_intersection_unit uut (.*);

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // rounded integer square root
  function automatic logic [63:0] sqrt_nearest(logic [63:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  // expected line of two planes at a given tolerance
  function automatic line_t intersect_planes(plane_pair_t p, logic [14:0] tol);
    longint n1[3], n2[3], u[3], c1[3], c2[3];
    longint dot, upper, lower;
    logic [63:0] s, m;
    logic signed [127:0] wc1, wc2, wd1, wd2, num;
    logic [127:0] mag, den, q, rem, lim, sq;
    logic neg;
    logic [31:0] pt[3];
    logic [15:0] dir[3];
    line_t r;
    r = '{default: '0};
    n1[0] = p.ax; n1[1] = p.ay; n1[2] = p.az;
    n2[0] = p.bx; n2[1] = p.by; n2[2] = p.bz;
    dot = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
    upper = (longint'(1) << 28) + (longint'(tol) << 14);
    lower = (longint'(1) << 28) - (longint'(tol) << 14);
    if (dot < upper && dot > lower) return r;
    if (dot > -upper && dot < -lower) return r;
    u[0] = n1[1] * n2[2] - n1[2] * n2[1];
    u[1] = n1[2] * n2[0] - n1[0] * n2[2];
    u[2] = n1[0] * n2[1] - n1[1] * n2[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = u[i] < 0 ? -u[i] : u[i];
      s = s + m * m;
    end
    if (s == 0) return r;
    c1[0] = n1[1] * u[2] - n1[2] * u[1];
    c1[1] = n1[2] * u[0] - n1[0] * u[2];
    c1[2] = n1[0] * u[1] - n1[1] * u[0];
    c2[0] = n2[1] * u[2] - n2[2] * u[1];
    c2[1] = n2[2] * u[0] - n2[0] * u[2];
    c2[2] = n2[0] * u[1] - n2[1] * u[0];
    wd1 = p.ad;
    wd2 = p.bd;
    den = {64'd0, s};
    for (int i = 0; i < 3; i++) begin
      // point: numerator over s, rounded half away, saturated
      wc1 = c1[i];
      wc2 = c2[i];
      num = (wc1 * wd2 - wc2 * wd1) <<< 14;
      neg = num[127];
      mag = neg ? -num : num;
      q = mag / den;
      rem = mag % den;
      if (rem >= den - rem) q = q + 1;
      lim = neg ? 128'd2147483648 : 128'd2147483647;
      if (q > lim) q = lim;
      pt[i] = neg ? -q[31:0] : q[31:0];
      // direction: signed root of u_i^2 / s
      m = u[i] < 0 ? -u[i] : u[i];
      sq = {64'd0, m * m} << 28;
      q = sq / den;
      dir[i] = 16'(sqrt_nearest(q[63:0]));
      if (u[i] < 0) dir[i] = -dir[i];
    end
    r.found = 1'b1;
    r.px = pt[0]; r.py = pt[1]; r.pz = pt[2];
    r.dx = dir[0]; r.dy = dir[1]; r.dz = dir[2];
    return r;
  endfunction

  function automatic plane_pair_t make_pair(int ax, int ay, int az, int ad,
                                            int bx, int by, int bz, int bd);
    plane_pair_t p;
    p.ax = 16'(ax); p.ay = 16'(ay); p.az = 16'(az); p.ad = ad;
    p.bx = 16'(bx); p.by = 16'(by); p.bz = 16'(bz); p.bd = bd;
    return p;
  endfunction

  function automatic int small_signed(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // random plane pair, mostly well-formed geometry
  function automatic plane_pair_t random_pair();
    plane_pair_t p;
    int kind, sgn;
    kind = $urandom_range(0, 9);
    p.ax = 16'($urandom); p.ay = 16'($urandom); p.az = 16'($urandom);
    p.bx = 16'($urandom); p.by = 16'($urandom); p.bz = 16'($urandom);
    if (kind >= 2 && kind <= 4) begin
      // near parallel around a dominant axis
      sgn = $urandom_range(0, 1) ? 1 : -1;
      p.ax = 16'(16384 + small_signed(300));
      p.ay = 16'(small_signed(3000));
      p.az = 16'(small_signed(3000));
      p.bx = 16'(sgn * p.ax + small_signed(2500));
      p.by = 16'(sgn * p.ay + small_signed(2500));
      p.bz = 16'(sgn * p.az + small_signed(2500));
    end else if (kind == 5) begin
      p.bx = '0; p.by = '0; p.bz = '0;
    end else if (kind >= 6) begin
      p.ax = 16'(small_signed(16384));
      p.ay = 16'(small_signed(16384));
      p.az = 16'(small_signed(16384));
      p.bx = 16'(small_signed(16384));
      p.by = 16'(small_signed(16384));
      p.bz = 16'(small_signed(16384));
    end
    if ($urandom_range(0, 1)) begin
      p.ad = $urandom;
      p.bd = $urandom;
    end else begin
      p.ad = small_signed(1 << 20);
      p.bd = small_signed(1 << 20);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             line_count);
    error_count++;
  endtask

  task automatic write_tolerance(logic [14:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tolerance_now = value;
  endtask

  task automatic queue_random(int count);
    @(negedge clk_i);
    repeat (count) pending_pairs.push_back(random_pair());
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid_i || expected_lines.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // driver: offers queued pairs, predicts each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_lines.push_back(intersect_planes(offered_pair, tolerance_now));
        in_count <= in_count + 1;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the word until accepted
      end else if (tx_idle > 0) begin
        tx_idle--;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
        tx_idle = $urandom_range(1, 5) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        offered_pair = pending_pairs.pop_front();
        in_valid_i        <= 1'b1;
        first_normal_x_i  <= offered_pair.ax;
        first_normal_y_i  <= offered_pair.ay;
        first_normal_z_i  <= offered_pair.az;
        first_offset_i    <= offered_pair.ad;
        second_normal_x_i <= offered_pair.bx;
        second_normal_y_i <= offered_pair.by;
        second_normal_z_i <= offered_pair.bz;
        second_offset_i   <= offered_pair.bd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off to back the pipeline up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && in_count >= 150) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_idle = $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    line_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lines.size() == 0) begin
        $display("unexpected result word");
        error_count++;
      end else begin
        want = expected_lines.pop_front();
        if (line_valid_o !== want.found) report_mismatch("line_valid", line_valid_o, want.found);
        if (point_x_o !== want.px) report_mismatch("point_x", point_x_o, want.px);
        if (point_y_o !== want.py) report_mismatch("point_y", point_y_o, want.py);
        if (point_z_o !== want.pz) report_mismatch("point_z", point_z_o, want.pz);
        if (direction_x_o !== want.dx) report_mismatch("direction_x", direction_x_o, want.dx);
        if (direction_y_o !== want.dy) report_mismatch("direction_y", direction_y_o, want.dy);
        if (direction_z_o !== want.dz) report_mismatch("direction_z", direction_z_o, want.dz);
        if (want.found) found_count++;
      end
      line_count++;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed pairs at the reset tolerance
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(16384, 0, 0, 65536, 0, 16384, 0, -65536));
    pending_pairs.push_back(make_pair(16384, 0, 0, 1000, 16384, 0, 0, 2000));
    pending_pairs.push_back(make_pair(16384, 0, 0, 1000, -16384, 0, 0, 2000));
    // dot exactly on and just inside the tolerance edges
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, 18022, 5, 0, -4096));
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, 18021, 5, 0, -4096));
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, 14746, 5, 0, -4096));
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, 14747, 5, 0, -4096));
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, -18022, 5, 0, -4096));
    pending_pairs.push_back(make_pair(16384, 0, 0, 4096, -18021, 5, 0, -4096));
    // field extremes
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32'h7fffffff,
                                      -32768, 32767, -32768, 32'h80000000));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32'h80000000,
                                      32767, -32768, 0, 32'h7fffffff));
    // tiny normals push the point out of range
    pending_pairs.push_back(make_pair(1, 0, 0, 32'h7fffffff, 0, 1, 0, 32'h7fffffff));
    pending_pairs.push_back(make_pair(1, 0, 0, 32'h80000000, 0, 1, 0, 32'h80000000));
    // normals that are not unit length, zero second normal
    pending_pairs.push_back(make_pair(8000, 3000, -100, 123456, 200, -9000, 12000, -98765));
    pending_pairs.push_back(make_pair(8000, 3000, -100, 123456, 0, 0, 0, 5));
    repeat (200) pending_pairs.push_back(random_pair());
    drain();

    // zero tolerance: exact unit dot no longer counts as parallel
    write_tolerance(15'd0);
    @(negedge clk_i);
    pending_pairs.push_back(make_pair(16384, 0, 0, 65536, 16384, 1, 0, -65536));
    pending_pairs.push_back(make_pair(16384, 0, 0, 65536, -16384, 1, 0, 65536));
    pending_pairs.push_back(make_pair(16384, 0, 0, 65536, 16384, 0, 0, 65536));
    queue_random(120);
    drain();

    write_tolerance(15'h7fff);
    queue_random(120);
    drain();

    // tolerance above one
    write_tolerance(15'd20000);
    queue_random(100);
    drain();

    write_tolerance(15'($urandom_range(1, 16000)));
    queue_random(100);
    drain();

    // closing stretch at full rate
    write_tolerance(TOL_RESET);
    @(negedge clk_i);
    quiet = 1'b1;
    queue_random(100);
    drain();

    $display("covered %0d plane pairs over six tolerance settings, %0d of %0d lines found",
             in_count, found_count, line_count);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
src/ppi_pkg.sv
src/ppi_lane.sv
src/plane_plane_intersection_unit.sv
tb/tb_top.sv
